@@ rtl/rlbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Resistor-ladder button decoder package
// Shared constants, types and a helper function of the button decoder.
// ----------------------------------------------------------------------------
package rlbd_pkg;

  // Table depth and sample width.
  localparam int MAX_ENTRIES = 9;
  localparam int SAMPLE_BITS = 12;
  localparam int VSUM_BITS   = SAMPLE_BITS + 1;

  // Configuration register indexes.
  localparam logic [3:0] REG_SERIES_OHMS   = 4'd0;
  localparam logic [3:0] REG_SUPPLY_MV     = 4'd1;
  localparam logic [3:0] REG_CHECK_OHMS    = 4'd2;
  localparam logic [3:0] REG_LADDER_ENABLE = 4'd3;
  localparam logic [3:0] REG_LADDER_EXCL   = 4'd4;
  localparam logic [3:0] REG_ENTRY_COUNT   = 4'd5;
  localparam logic [3:0] REG_TOLERANCE_MV  = 4'd6;
  localparam logic [3:0] REG_MINIMUM_MV    = 4'd7;

  // Result status codes.
  localparam logic STATUS_MASK  = 1'b0;
  localparam logic STATUS_FAULT = 1'b1;

  // Item operations.
  localparam logic OP_POLL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [11:0] mv;
    logic [9:0]  spread;
    logic [19:0] ohms;
  } rlbd_entry_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_SCAN,
    S_LINIT,
    S_LTEST,
    S_LM1,
    S_LM2,
    S_LM3,
    S_LCMP,
    S_FRD,
    S_FM,
    S_FCMP,
    S_EMIT
  } rlbd_state_t;

  // True when the doubled voltage lies within four spreads of twice the entry voltage.
  function automatic logic near_entry(input logic [VSUM_BITS-1:0] v,
                                      input logic [11:0] mv,
                                      input logic [9:0] spread);
    logic [13:0] c;
    logic [13:0] s;
    logic [13:0] vv;
    c  = {1'b0, mv, 1'b0};
    s  = {2'b00, spread, 2'b00};
    vv = 14'(v);
    return (vv <= c + s) && (vv + s >= c);
  endfunction

endpackage

@@ rtl/rlbd_if.sv @@
// ----------------------------------------------------------------------------
// Resistor-ladder button decoder channels
// Valid/ready interfaces for the item, result and configuration channels.
// ----------------------------------------------------------------------------

// Input item channel.
interface rlbd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] sample_1a;
  logic [11:0] sample_1b;
  logic [11:0] sample_2a;
  logic [11:0] sample_2b;
  logic [3:0]  entry_index;
  logic [11:0] entry_mv;
  logic [9:0]  entry_spread_mv;
  logic [19:0] entry_ohms;

  modport source (output valid, op, sample_1a, sample_1b, sample_2a, sample_2b,
                  entry_index, entry_mv, entry_spread_mv, entry_ohms,
                  input ready);
  modport sink (input valid, op, sample_1a, sample_1b, sample_2a, sample_2b,
                entry_index, entry_mv, entry_spread_mv, entry_ohms,
                output ready);
endinterface

// Result channel.
interface rlbd_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  button_mask;
  logic [12:0] voltage_x2;

  modport source (output valid, status, button_mask, voltage_x2, input ready);
  modport sink (input valid, status, button_mask, voltage_x2, output ready);
endinterface

// Configuration write channel.
interface rlbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/resistor_ladder_button_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Resistor-ladder button decoder
// Filters sample pairs, matches them against a table of button voltages and
// runs an optional multi-button ladder decode; reports mask changes and faults.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Moves
//   in_ch    sink       load item (one table entry) or poll item (four samples)
//   out_ch   source     status, button mask and doubled voltage
//   cfg_ch   sink       register index and write data, always ready
//
// A load only writes the table entry; the sequencer stays idle. A poll runs
// one sample round per cycle (two at most), one single-button entry per cycle
// (up to 8) plus a scan end step, and with the ladder decode a start step, the
// LTEST, LM1, LM2, LM3 and LCMP steps per ladder entry (up to 8), the final
// bound test in FRD, FM and FCMP and a result hand-over that can wait on out_ch.
// Reset sets the sequencer, configuration, output valid and last mask; the
// datapath registers and table memory are not cleared. A new item is taken
// while a result waits in the output register; only a second result stalls
// until the first transfer completes.

module resistor_ladder_button_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  rlbd_in_if.sink    in_ch,
  rlbd_out_if.source out_ch,
  rlbd_cfg_if.sink   cfg_ch
);

  localparam int VW = rlbd_pkg::VSUM_BITS;

  // Configuration registers.
  logic [19:0] series_r;
  logic [11:0] supply_r;
  logic [19:0] check_r;
  logic        lad_en_r;
  logic [3:0]  lad_excl_r;
  logic [3:0]  ent_cnt_r;
  logic [11:0] tol_r;
  logic [11:0] min_r;

  rlbd_pkg::rlbd_state_t state_r, state_nxt;

  // Poll context.
  logic [11:0]   s1a_r, s1b_r, s2a_r, s2b_r;
  logic          round_r, round_nxt;
  logic [VW-1:0] first_r, first_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [3:0]    k_r, k_nxt;

  // Ladder datapath.
  logic signed [25:0] acc_r, acc_nxt;
  logic signed [25:0] d_r, d_nxt;
  logic signed [26:0] den_r, den_nxt;
  logic signed [15:0] off_r, off_nxt;
  logic signed [43:0] num_r, num_nxt;
  logic signed [43:0] lhs_r, lhs_nxt;
  logic signed [43:0] prod_r, prod_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic [3:0]         last_r, last_nxt;
  logic [3:0]         hits_r, hits_nxt;

  // Pending result and output register.
  logic          res_status_r, res_status_nxt;
  logic [7:0]    res_mask_r, res_mask_nxt;
  logic          out_valid_r;
  logic          out_status_r;
  logic [7:0]    out_mask_r;
  logic [VW-1:0] out_v_r;
  logic [7:0]    last_mask_r;
  logic          load_out;

  // Table memory.
  rlbd_pkg::rlbd_entry_t mem [rlbd_pkg::MAX_ENTRIES];
  rlbd_pkg::rlbd_entry_t rdata_r;
  logic [3:0]            rd_addr;

  logic in_xfer;
  assign in_ch.ready  = (state_r == rlbd_pkg::S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r   <= 20'd10000;
      supply_r   <= 12'd3300;
      check_r    <= 20'd0;
      lad_en_r   <= 1'b0;
      lad_excl_r <= 4'd0;
      ent_cnt_r  <= 4'd9;
      tol_r      <= 12'd50;
      min_r      <= 12'd100;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rlbd_pkg::REG_SERIES_OHMS:   series_r   <= cfg_ch.data;
        rlbd_pkg::REG_SUPPLY_MV:     supply_r   <= cfg_ch.data[11:0];
        rlbd_pkg::REG_CHECK_OHMS:    check_r    <= cfg_ch.data;
        rlbd_pkg::REG_LADDER_ENABLE: lad_en_r   <= cfg_ch.data[0];
        rlbd_pkg::REG_LADDER_EXCL:   lad_excl_r <= cfg_ch.data[3:0];
        rlbd_pkg::REG_ENTRY_COUNT:   ent_cnt_r  <= cfg_ch.data[3:0];
        rlbd_pkg::REG_TOLERANCE_MV:  tol_r      <= cfg_ch.data[11:0];
        rlbd_pkg::REG_MINIMUM_MV:    min_r      <= cfg_ch.data[11:0];
        default: ;
      endcase
    end
  end

  // Table memory: written by load items, read one entry per cycle.
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.op == rlbd_pkg::OP_LOAD &&
        in_ch.entry_index < 4'(rlbd_pkg::MAX_ENTRIES)) begin
      mem[in_ch.entry_index] <= '{mv: in_ch.entry_mv, spread: in_ch.entry_spread_mv,
                                  ohms: in_ch.entry_ohms};
    end
    if (rd_addr < 4'(rlbd_pkg::MAX_ENTRIES)) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rd_addr = k_nxt;

  // Sample round evaluation.
  logic [11:0]   smp_a, smp_b, smp_diff;
  logic [VW-1:0] smp_sum, smp_dv;
  logic          rnd_reject, rnd_fault, rnd_idle;

  always_comb begin
    smp_a      = round_r ? s2a_r : s1a_r;
    smp_b      = round_r ? s2b_r : s1b_r;
    smp_diff   = (smp_a > smp_b) ? smp_a - smp_b : smp_b - smp_a;
    smp_sum    = {1'b0, smp_a} + {1'b0, smp_b};
    smp_dv     = (smp_sum > first_r) ? smp_sum - first_r : first_r - smp_sum;
    rnd_reject = (smp_diff > tol_r) || (round_r && (smp_dv > {tol_r, 1'b0}));
    rnd_fault  = (check_r != 20'd0) && (smp_sum < {min_r, 1'b0});
    rnd_idle   = rlbd_pkg::near_entry(smp_sum, rdata_r.mv, rdata_r.spread);
  end

  // Entry limits.
  logic [3:0]        n_used;
  logic signed [5:0] lad_top;
  logic              k_past_top;
  assign n_used     = (ent_cnt_r > 4'(rlbd_pkg::MAX_ENTRIES)) ?
                      4'(rlbd_pkg::MAX_ENTRIES) : ent_cnt_r;
  assign lad_top    = $signed({2'b00, n_used}) - $signed({2'b00, lad_excl_r});
  assign k_past_top = $signed({2'b00, k_r}) >= lad_top;

  // Shared multiplier.
  logic signed [15:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [43:0] mul_p;
  logic signed [27:0] den_ext;
  assign den_ext = 28'(den_r);
  assign mul_p   = 44'(mul_a) * 44'(mul_b);

  // Cross-multiplied bound compare.
  logic signed [43:0] rhs;
  logic               bound_ok;
  assign rhs      = (num_r <<< 1) + prod_r;
  assign bound_ok = (den_r > 27'sd0) ? (lhs_r <= rhs) :
                    (den_r < 27'sd0) ? (lhs_r >= rhs) : 1'b0;

  logic [7:0] bit_k, bit_last;
  assign bit_k    = 8'd1 << 3'(k_r - 4'd1);
  assign bit_last = 8'd1 << 3'(last_r - 4'd1);

  logic [7:0] fin_mask;
  logic [3:0] fin_hits;

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    round_nxt      = round_r;
    first_nxt      = first_r;
    v_nxt          = v_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    d_nxt          = d_r;
    den_nxt        = den_r;
    off_nxt        = off_r;
    num_nxt        = num_r;
    lhs_nxt        = lhs_r;
    prod_nxt       = prod_r;
    mask_nxt       = mask_r;
    last_nxt       = last_r;
    hits_nxt       = hits_r;
    res_status_nxt = res_status_r;
    res_mask_nxt   = res_mask_r;
    mul_a          = '0;
    mul_b          = '0;
    load_out       = 1'b0;
    fin_mask       = mask_r;
    fin_hits       = hits_r;

    case (state_r)
      rlbd_pkg::S_IDLE: begin
        k_nxt     = 4'd0;
        round_nxt = 1'b0;
        if (in_xfer && in_ch.op == rlbd_pkg::OP_POLL) begin
          state_nxt = rlbd_pkg::S_ROUND;
        end
      end

      // One sample round per cycle; entry 0 is on the read port.
      rlbd_pkg::S_ROUND: begin
        if (rnd_reject) begin
          state_nxt = rlbd_pkg::S_IDLE;
        end else if (rnd_fault) begin
          v_nxt          = smp_sum;
          res_status_nxt = rlbd_pkg::STATUS_FAULT;
          res_mask_nxt   = 8'd0;
          state_nxt      = rlbd_pkg::S_EMIT;
        end else if (rnd_idle) begin
          v_nxt          = smp_sum;
          res_status_nxt = rlbd_pkg::STATUS_MASK;
          res_mask_nxt   = 8'd0;
          state_nxt      = rlbd_pkg::S_EMIT;
        end else if (!round_r) begin
          first_nxt = smp_sum;
          round_nxt = 1'b1;
        end else begin
          v_nxt     = smp_sum;
          k_nxt     = 4'd1;
          state_nxt = rlbd_pkg::S_SCAN;
        end
      end

      // Single-button scan, one entry per cycle.
      rlbd_pkg::S_SCAN: begin
        if (k_r >= n_used) begin
          if (lad_en_r) begin
            k_nxt     = 4'd0;
            state_nxt = rlbd_pkg::S_LINIT;
          end else begin
            state_nxt = rlbd_pkg::S_IDLE;
          end
        end else if (rlbd_pkg::near_entry(v_r, rdata_r.mv, rdata_r.spread)) begin
          res_status_nxt = rlbd_pkg::STATUS_MASK;
          res_mask_nxt   = bit_k;
          state_nxt      = rlbd_pkg::S_EMIT;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end

      // Ladder start: accumulator from entry 0 and the check resistor.
      rlbd_pkg::S_LINIT: begin
        acc_nxt   = $signed({6'd0, rdata_r.ohms}) + $signed({6'd0, check_r});
        mask_nxt  = 8'd0;
        hits_nxt  = 4'd0;
        last_nxt  = 4'd0;
        k_nxt     = 4'd1;
        state_nxt = rlbd_pkg::S_LTEST;
      end

      rlbd_pkg::S_LTEST: begin
        if (k_past_top) begin
          if (mask_r != 8'd0) begin
            k_nxt     = last_r;
            state_nxt = rlbd_pkg::S_FRD;
          end else begin
            state_nxt = rlbd_pkg::S_IDLE;
          end
        end else begin
          d_nxt     = acc_r - $signed({6'd0, rdata_r.ohms});
          den_nxt   = $signed({7'd0, series_r}) + 27'(d_nxt);
          off_nxt   = $signed({4'd0, rdata_r.spread, 2'b00});
          state_nxt = rlbd_pkg::S_LM1;
        end
      end

      rlbd_pkg::S_LM1: begin
        mul_a     = $signed({4'd0, supply_r});
        mul_b     = 28'(d_r);
        num_nxt   = mul_p;
        state_nxt = rlbd_pkg::S_LM2;
      end

      rlbd_pkg::S_LM2: begin
        mul_a     = $signed(16'(v_r));
        mul_b     = den_ext;
        lhs_nxt   = mul_p;
        state_nxt = rlbd_pkg::S_LM3;
      end

      rlbd_pkg::S_LM3: begin
        mul_a     = off_r;
        mul_b     = den_ext;
        prod_nxt  = mul_p;
        state_nxt = rlbd_pkg::S_LCMP;
      end

      rlbd_pkg::S_LCMP: begin
        if (bound_ok) begin
          mask_nxt = mask_r | bit_k;
          last_nxt = k_r;
          hits_nxt = hits_r + 4'd1;
          acc_nxt  = d_r;
        end
        k_nxt     = k_r + 4'd1;
        state_nxt = rlbd_pkg::S_LTEST;
      end

      // Lower bound on the last tested entry, offset by the last match.
      rlbd_pkg::S_FRD: begin
        off_nxt   = 16'sd0 - $signed({3'd0, rdata_r.spread, 3'b000});
        state_nxt = rlbd_pkg::S_FM;
      end

      rlbd_pkg::S_FM: begin
        mul_a     = off_r;
        mul_b     = den_ext;
        prod_nxt  = mul_p;
        state_nxt = rlbd_pkg::S_FCMP;
      end

      rlbd_pkg::S_FCMP: begin
        if (bound_ok) begin
          fin_mask = mask_r & ~bit_last;
          fin_hits = hits_r - 4'd1;
        end
        mask_nxt = fin_mask;
        hits_nxt = fin_hits;
        if (fin_hits < 4'd2 || fin_mask == 8'd0) begin
          state_nxt = rlbd_pkg::S_IDLE;
        end else begin
          res_status_nxt = rlbd_pkg::STATUS_MASK;
          res_mask_nxt   = fin_mask;
          state_nxt      = rlbd_pkg::S_EMIT;
        end
      end

      // Hand the result to the output register, dropping unchanged masks.
      rlbd_pkg::S_EMIT: begin
        if (res_status_r == rlbd_pkg::STATUS_MASK && res_mask_r == last_mask_r) begin
          state_nxt = rlbd_pkg::S_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = rlbd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rlbd_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlbd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    round_r      <= round_nxt;
    first_r      <= first_nxt;
    v_r          <= v_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    d_r          <= d_nxt;
    den_r        <= den_nxt;
    off_r        <= off_nxt;
    num_r        <= num_nxt;
    lhs_r        <= lhs_nxt;
    prod_r       <= prod_nxt;
    mask_r       <= mask_nxt;
    last_r       <= last_nxt;
    hits_r       <= hits_nxt;
    res_status_r <= res_status_nxt;
    res_mask_r   <= res_mask_nxt;
    if (in_xfer) begin
      s1a_r <= in_ch.sample_1a;
      s1b_r <= in_ch.sample_1b;
      s2a_r <= in_ch.sample_2a;
      s2b_r <= in_ch.sample_2b;
    end
  end

  // Output register and last reported mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_mask_r <= 8'd0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (res_status_r == rlbd_pkg::STATUS_MASK) begin
          last_mask_r <= res_mask_r;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_mask_r   <= res_mask_r;
      out_v_r      <= v_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.button_mask = out_mask_r;
  assign out_ch.voltage_x2  = out_v_r;

`ifndef SYNTHESIS
  // A reported mask becomes the new reference mask.
  a_last_mask_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_status_r == rlbd_pkg::STATUS_MASK) |=> last_mask_r == out_ch.button_mask)
    else $error("last mask not updated by reported result");

  // Fault results never carry a button.
  a_fault_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == rlbd_pkg::STATUS_FAULT) |-> out_ch.button_mask == 8'd0)
    else $error("fault result with nonzero mask");

  // During the ladder walk the match count equals the set mask bits.
  a_hits_match_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlbd_pkg::S_LTEST) |-> 32'(hits_r) == $countones(mask_r))
    else $error("ladder match count out of step with mask");

  // A result is never loaded over one that waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_valid_r) |-> out_ch.ready)
    else $error("output register overwritten");
`endif

endmodule
